// ===== hw/rtl/nhse_pkg.sv =====
package nhse_pkg;

    localparam int unsigned WideW = 64;
    localparam logic signed [63:0] WideMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] WideMin = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] OneQ = 64'sd65536;
    localparam logic signed [63:0] ThreeQ = 64'sd196608;
    localparam logic signed [63:0] HalfQ = 64'sd32768;
    localparam logic [30:0] MuReset = 31'd65536;
    localparam logic [31:0] LambdaReset = 32'd65536;
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] RegShear = 1'b0;
    localparam logic [CfgIdxW-1:0] RegLambda = 1'b1;

    typedef struct packed {
        logic signed [31:0] f_r0c0;
        logic signed [31:0] f_r0c1;
        logic signed [31:0] f_r0c2;
        logic signed [31:0] f_r1c0;
        logic signed [31:0] f_r1c1;
        logic signed [31:0] f_r1c2;
        logic signed [31:0] f_r2c0;
        logic signed [31:0] f_r2c1;
        logic signed [31:0] f_r2c2;
    } t_in;

    typedef struct packed {
        logic signed [31:0] p_r0c0;
        logic signed [31:0] p_r0c1;
        logic signed [31:0] p_r0c2;
        logic signed [31:0] p_r1c0;
        logic signed [31:0] p_r1c1;
        logic signed [31:0] p_r1c2;
        logic signed [31:0] p_r2c0;
        logic signed [31:0] p_r2c1;
        logic signed [31:0] p_r2c2;
        logic signed [63:0] strain_energy;
    } t_out;

    // saturating add of two wide values
    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return WideMax;
        if (s < -65'sh0_8000_0000_0000_0000) return WideMin;
        return s[63:0];
    endfunction

    // saturating subtract of two wide values
    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return WideMax;
        if (s < -65'sh0_8000_0000_0000_0000) return WideMin;
        return s[63:0];
    endfunction

    // round a sign-magnitude product to q16.16, ties away from zero, saturate
    function automatic logic signed [63:0] rnd_sat(input logic neg,
                                                   input logic [127:0] pm);
        logic [127:0] r;
        logic [111:0] q;
        r = pm + 128'd32768;
        q = r[127:16];
        if (q[111:63] != '0) begin
            if (neg && q[111:64] == '0 && q[62:0] == '0) return WideMin;
            return neg ? WideMin : WideMax;
        end
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    // saturate to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) return 32'sh8000_0000;
        return x[31:0];
    endfunction

endpackage

// ===== hw/rtl/nhse_mul.sv =====
// q16.16 wide product in two stages: 32x32 partial products, then sum and round
module nhse_mul (
    input  logic               i_clk,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p
);
    import nhse_pkg::*;

    logic        r_neg;
    logic [63:0] r_p00, r_p01, r_p10, r_p11;
    logic [63:0] ma, mb;
    logic [127:0] sum;

    assign ma = i_a[63] ? 64'd0 - i_a : i_a;
    assign mb = i_b[63] ? 64'd0 - i_b : i_b;

    // partial products
    always_ff @(posedge i_clk) begin
        r_neg <= i_a[63] ^ i_b[63];
        r_p00 <= ma[31:0] * mb[31:0];
        r_p01 <= ma[31:0] * mb[63:32];
        r_p10 <= ma[63:32] * mb[31:0];
        r_p11 <= ma[63:32] * mb[63:32];
    end

    assign sum = {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
               + {r_p11, 64'd0};

    // combine and round
    always_ff @(posedge i_clk) begin
        o_p <= rnd_sat(r_neg, sum);
    end
endmodule

// ===== hw/rtl/neo_hookean_stress_energy_unit.sv =====
// Stable neo-Hookean PK1 stress and strain energy. One matrix is taken per
// cycle (start is honored whenever busy is low, and busy stays low);
// each result appears on o_result with o_done high for one cycle. The path
// runs through a chain of five dependent two-stage multipliers (cofactor,
// determinant, lambdaHat*(J-1), products, halving) plus add and output stages.
// The receiver cannot stall the output.
module neo_hookean_stress_energy_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  nhse_pkg::t_in         i_item,
    output logic                  o_done,
    output nhse_pkg::t_out        o_result,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data
);
    import nhse_pkg::*;

    localparam int unsigned Lat = 15;

    logic [30:0] r_mu;
    logic [31:0] r_lambda;
    logic [Lat-1:0] r_vld;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu <= MuReset;
            r_lambda <= LambdaReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegShear:  r_mu <= i_cfg_data[30:0];
                RegLambda: r_lambda <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [63:0] mu, lhat;
    assign mu = {33'd0, r_mu};
    assign lhat = sadd({{32{r_lambda[31]}}, r_lambda}, mu);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[Lat-2:0], start};
    end

    logic signed [63:0] f [9];
    assign f[0] = 64'(i_item.f_r0c0); assign f[1] = 64'(i_item.f_r0c1);
    assign f[2] = 64'(i_item.f_r0c2); assign f[3] = 64'(i_item.f_r1c0);
    assign f[4] = 64'(i_item.f_r1c1); assign f[5] = 64'(i_item.f_r1c2);
    assign f[6] = 64'(i_item.f_r2c0); assign f[7] = 64'(i_item.f_r2c1);
    assign f[8] = 64'(i_item.f_r2c2);

    // stage a: cofactor products, mu*f, squares
    logic signed [63:0] pa [9], pb [9], mf [9], sq [9];
    genvar g;
    generate
        for (g = 0; g < 9; g++) begin : g_a
            localparam int R = g / 3, C = g % 3;
            localparam int R1 = (R + 1) % 3, R2 = (R + 2) % 3;
            localparam int C1 = (C + 1) % 3, C2 = (C + 2) % 3;
            nhse_mul u_pa (.i_clk, .i_a(f[R1*3+C1]), .i_b(f[R2*3+C2]), .o_p(pa[g]));
            nhse_mul u_pb (.i_clk, .i_a(f[R1*3+C2]), .i_b(f[R2*3+C1]), .o_p(pb[g]));
            nhse_mul u_mf (.i_clk, .i_a(mu), .i_b(f[g]), .o_p(mf[g]));
            nhse_mul u_sq (.i_clk, .i_a(f[g]), .i_b(f[g]), .o_p(sq[g]));
        end
    endgenerate

    // f row 0 delayed through r_f0d1 and r_f0d2 for the determinant
    logic signed [63:0] r_f0d1 [3], r_f0d2 [3];
    logic signed [63:0] r_cof [9];
    logic signed [63:0] r_mf3 [9];
    logic signed [63:0] r_nsq3;
    logic signed [63:0] r_sq3 [6];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_f0d1[k] <= f[k];
            r_f0d2[k] <= r_f0d1[k];
        end
    end

    // cofactors, first part of norm sum
    always_ff @(posedge i_clk) begin
        logic signed [63:0] acc;
        acc = '0;
        for (int k = 0; k < 9; k++) begin
            r_cof[k] <= ssub(pa[k], pb[k]);
            r_mf3[k] <= mf[k];
        end
        for (int k = 0; k < 3; k++) acc = sadd(acc, sq[k]);
        for (int k = 0; k < 6; k++) r_sq3[k] <= sq[k+3];
        r_nsq3 <= acc;
    end

    // norm sum continued, three squares per cycle
    logic signed [63:0] r_nsq4, r_nsq5;
    logic signed [63:0] r_sq4 [3];
    always_ff @(posedge i_clk) begin
        logic signed [63:0] acc1;
        acc1 = r_nsq3;
        for (int k = 0; k < 3; k++) begin
            acc1 = sadd(acc1, r_sq3[k]);
            r_sq4[k] <= r_sq3[k+3];
        end
        r_nsq4 <= acc1;
    end

    always_ff @(posedge i_clk) begin
        logic signed [63:0] acc2;
        acc2 = r_nsq4;
        for (int k = 0; k < 3; k++) acc2 = sadd(acc2, r_sq4[k]);
        r_nsq5 <= acc2;
    end

    // stage b: determinant products
    logic signed [63:0] r_f0d3 [3];
    logic signed [63:0] dp [3];
    always_ff @(posedge i_clk) for (int k = 0; k < 3; k++) r_f0d3[k] <= r_f0d2[k];
    generate
        for (g = 0; g < 3; g++) begin : g_b
            nhse_mul u_d (.i_clk, .i_a(r_f0d3[g]), .i_b(r_cof[g]), .o_p(dp[g]));
        end
    endgenerate

    // delay cof and mu*f through the pipe
    logic signed [63:0] r_cof4 [9], r_cof5 [9], r_cof6 [9], r_cof7 [9], r_cof8 [9];
    logic signed [63:0] r_cof9 [9];
    logic signed [63:0] r_mf4 [9], r_mf5 [9], r_mf6 [9], r_mf7 [9], r_mf8 [9];
    logic signed [63:0] r_mf9 [9], r_mf10 [9], r_mf11 [9];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_cof4[k] <= r_cof[k]; r_cof5[k] <= r_cof4[k]; r_cof6[k] <= r_cof5[k];
            r_cof7[k] <= r_cof6[k]; r_cof8[k] <= r_cof7[k]; r_cof9[k] <= r_cof8[k];
            r_mf4[k] <= r_mf3[k]; r_mf5[k] <= r_mf4[k]; r_mf6[k] <= r_mf5[k];
            r_mf7[k] <= r_mf6[k]; r_mf8[k] <= r_mf7[k]; r_mf9[k] <= r_mf8[k];
            r_mf10[k] <= r_mf9[k]; r_mf11[k] <= r_mf10[k];
        end
    end

    // J-1, |F|^2-3
    logic signed [63:0] r_jm1, r_n3;
    always_ff @(posedge i_clk) begin
        r_jm1 <= ssub(sadd(sadd(sadd('0, dp[0]), dp[1]), dp[2]), OneQ);
        r_n3 <= ssub(r_nsq5, ThreeQ);
    end

    // stage c: lj, mu*jm1, mu*(n-3)
    logic signed [63:0] lj, mj, mn;
    nhse_mul u_lj (.i_clk, .i_a(lhat), .i_b(r_jm1), .o_p(lj));
    nhse_mul u_mj (.i_clk, .i_a(mu), .i_b(r_jm1), .o_p(mj));
    nhse_mul u_mn (.i_clk, .i_a(mu), .i_b(r_n3), .o_p(mn));
    logic signed [63:0] r_jm1d7, r_jm1d8, r_coeff, r_lj9, r_jm19;
    logic signed [63:0] r_mj9, r_mj10, r_mj11, r_mj12;
    always_ff @(posedge i_clk) begin
        r_jm1d7 <= r_jm1; r_jm1d8 <= r_jm1d7;
        r_coeff <= ssub(lj, mu);
        r_lj9 <= lj; r_jm19 <= r_jm1d8;
        r_mj9 <= mj; r_mj10 <= r_mj9; r_mj11 <= r_mj10; r_mj12 <= r_mj11;
    end

    // stage d: coeff*cof, lj*jm1, half of mu*(n-3)
    logic signed [63:0] cc [9], ljj, hmn;
    generate
        for (g = 0; g < 9; g++) begin : g_d
            nhse_mul u_c (.i_clk, .i_a(r_coeff), .i_b(r_cof9[g]), .o_p(cc[g]));
        end
    endgenerate
    nhse_mul u_ljj (.i_clk, .i_a(r_lj9), .i_b(r_jm19), .o_p(ljj));
    logic signed [63:0] r_mn9;
    always_ff @(posedge i_clk) r_mn9 <= mn;
    nhse_mul u_hmn (.i_clk, .i_a(r_mn9), .i_b(HalfQ), .o_p(hmn));

    // stress sums, first energy term
    logic signed [31:0] r_p12 [9], r_p13 [9], r_p14 [9];
    logic signed [63:0] r_w12, r_ljj12, r_w13, r_w14;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_p12[k] <= sat32(sadd(r_mf11[k], cc[k]));
            r_p13[k] <= r_p12[k]; r_p14[k] <= r_p13[k];
        end
        r_w12 <= hmn; r_ljj12 <= ljj;
        r_w13 <= ssub(r_w12, r_mj12);
    end

    // stage e: half of lj*jm1
    logic signed [63:0] hlj;
    nhse_mul u_hlj (.i_clk, .i_a(r_ljj12), .i_b(HalfQ), .o_p(hlj));
    always_ff @(posedge i_clk) r_w14 <= r_w13;

    // output register
    always_ff @(posedge i_clk) begin
        o_result.p_r0c0 <= r_p14[0]; o_result.p_r0c1 <= r_p14[1];
        o_result.p_r0c2 <= r_p14[2]; o_result.p_r1c0 <= r_p14[3];
        o_result.p_r1c1 <= r_p14[4]; o_result.p_r1c2 <= r_p14[5];
        o_result.p_r2c0 <= r_p14[6]; o_result.p_r2c1 <= r_p14[7];
        o_result.p_r2c2 <= r_p14[8];
        o_result.strain_energy <= sadd(r_w14, hlj);
    end
    assign o_done = r_vld[Lat-1];
endmodule
